// ===== rtl/core/olse_pkg.sv =====
// Shared types, constants and helpers of the ordered list store engine.
`default_nettype none

package olse_pkg;

	// Pool size and derived widths; a link one past the last slot is the null marker.
	localparam int CAPACITY = 32;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int LINK_W   = $clog2(CAPACITY + 1);

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [LINK_W-1:0] link_t;

	localparam link_t NULL_LINK = LINK_W'(CAPACITY);

	// Request codes.
	localparam logic [2:0] FUNC_APPEND   = 3'd0;
	localparam logic [2:0] FUNC_SEARCH   = 3'd1;
	localparam logic [2:0] FUNC_REMOVE   = 3'd2;
	localparam logic [2:0] FUNC_LIST_FWD = 3'd3;
	localparam logic [2:0] FUNC_LIST_BWD = 3'd4;

	// Response status codes.
	localparam logic [2:0] ST_APPENDED   = 3'd0;
	localparam logic [2:0] ST_FOUND      = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND  = 3'd2;
	localparam logic [2:0] ST_FULL       = 3'd3;
	localparam logic [2:0] ST_LIST_ENTRY = 3'd4;
	localparam logic [2:0] ST_LIST_EMPTY = 3'd5;

	// Request and response words.
	typedef struct packed {
		logic [2:0]         func;
		logic signed [31:0] value;
	} req_word_t;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [31:0] item;
		logic               last;
	} rsp_word_t;

	// One slot of the list memory.
	typedef struct packed {
		logic signed [31:0] value;
		link_t              next;
		link_t              prev;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Bit masks for partial slot writes.
	localparam entry_t MASK_ALL  = '{value: '1, next: '1, prev: '1};
	localparam entry_t MASK_NEXT = '{value: '0, next: '1, prev: '0};
	localparam entry_t MASK_PREV = '{value: '0, next: '0, prev: '1};

	// Memory access request from the sequencer.
	typedef struct packed {
		logic   rd_en;
		idx_t   rd_addr;
		logic   wr_en;
		idx_t   wr_addr;
		entry_t wr_mask;
		entry_t wr_data;
	} mem_req_t;

	// Slot pool command and status.
	typedef struct packed {
		logic alloc;
		logic drop;
		idx_t slot;
	} pool_cmd_t;

	typedef struct packed {
		idx_t free_slot;
		logic full;
	} pool_stat_t;

	// A link points at a slot when it is below the null marker.
	function automatic logic link_ok(link_t l);
		return l < NULL_LINK;
	endfunction

	function automatic idx_t to_idx(link_t l);
		return l[IDX_W-1:0];
	endfunction

	function automatic link_t to_link(idx_t i);
		return LINK_W'(i);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/olse_ram.sv =====
// Generic simple dual-port RAM with bit write mask and registered read data.
`default_nettype none

module olse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [WIDTH-1:0]  rd_data,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]  wr_mask,
	input  wire logic [WIDTH-1:0]  wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write only the masked bits of the addressed word.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int i = 0; i < WIDTH; i++) begin
				if (wr_mask[i]) begin
					mem[wr_addr][i] <= wr_data[i];
				end
			end
		end
	end

	// Read data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/olse_pool.sv =====
// Slot pool: occupancy flags and lowest free slot search.
`default_nettype none

module olse_pool
	import olse_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire pool_cmd_t  pool_cmd,
	output pool_stat_t      pool_stat
);

	logic [CAPACITY-1:0] in_use_q;

	// Priority encoder picks the lowest free slot.
	always_comb begin
		pool_stat.free_slot = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				pool_stat.free_slot = IDX_W'(i);
			end
		end
		pool_stat.full = &in_use_q;
	end

	// Claim a slot on append, return it on removal.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
		end else begin
			if (pool_cmd.alloc) begin
				in_use_q[pool_stat.free_slot] <= 1'b1;
			end
			if (pool_cmd.drop) begin
				in_use_q[pool_cmd.slot] <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/olse_seq.sv =====
// Sequencer: request decode, link walks, list updates and response register.
`default_nettype none

module olse_seq
	import olse_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_stall,
	input  wire req_word_t  req,
	output logic            rsp_valid,
	input  wire logic       rsp_stall,
	output rsp_word_t       rsp,
	output mem_req_t        mem_req,
	input  wire entry_t     rd_entry,
	output pool_cmd_t       pool_cmd,
	input  wire pool_stat_t pool_stat
);

	typedef enum logic [5:0] {
		S_IDLE     = 6'b000001,
		S_APP_LINK = 6'b000010,
		S_WALK     = 6'b000100,
		S_UNLINK   = 6'b001000,
		S_LIST     = 6'b010000,
		S_RESP     = 6'b100000
	} seq_state_t;

	seq_state_t state_q, state_d;
	link_t      head_q, head_d, tail_q, tail_d;
	logic       rsp_valid_q;
	logic       rsp_load;
	rsp_word_t  rsp_q, rsp_d;
	req_word_t  req_q, req_d;
	idx_t       cur_q, cur_d;
	link_t      p_q, p_d, n_q, n_d;
	logic [2:0] status_q, status_d;
	logic       slot_free;
	link_t      start_link;
	link_t      list_link;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign slot_free = !rsp_valid_q || !rsp_stall;

	// Start of a listing and the link to follow after the current entry.
	assign start_link = (req.func == FUNC_LIST_FWD) ? head_q : tail_q;
	assign list_link  = (req_q.func == FUNC_LIST_FWD) ? rd_entry.next : rd_entry.prev;

	// Next state and memory accesses. Writes and reads never share a cycle on
	// the same slot, since each update step is a state of its own.
	always_comb begin
		state_d  = state_q;
		head_d   = head_q;
		tail_d   = tail_q;
		req_d    = req_q;
		cur_d    = cur_q;
		p_d      = p_q;
		n_d      = n_q;
		status_d = status_q;
		rsp_d    = rsp_q;
		rsp_load = 1'b0;
		mem_req  = '0;
		pool_cmd = '0;

		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					req_d = req;
					case (req.func)
						FUNC_APPEND: begin
							if (pool_stat.full) begin
								status_d = ST_FULL;
								state_d  = S_RESP;
							end else begin
								mem_req.wr_en   = 1'b1;
								mem_req.wr_addr = pool_stat.free_slot;
								mem_req.wr_mask = MASK_ALL;
								mem_req.wr_data = '{value: req.value, next: NULL_LINK,
									prev: tail_q};
								pool_cmd.alloc  = 1'b1;
								tail_d   = to_link(pool_stat.free_slot);
								status_d = ST_APPENDED;
								if (link_ok(tail_q)) begin
									p_d     = tail_q;
									state_d = S_APP_LINK;
								end else begin
									head_d  = to_link(pool_stat.free_slot);
									state_d = S_RESP;
								end
							end
						end
						FUNC_SEARCH, FUNC_REMOVE: begin
							if (link_ok(head_q)) begin
								mem_req.rd_en   = 1'b1;
								mem_req.rd_addr = to_idx(head_q);
								cur_d   = to_idx(head_q);
								state_d = S_WALK;
							end else begin
								status_d = ST_NOT_FOUND;
								state_d  = S_RESP;
							end
						end
						FUNC_LIST_FWD, FUNC_LIST_BWD: begin
							if (link_ok(start_link)) begin
								mem_req.rd_en   = 1'b1;
								mem_req.rd_addr = to_idx(start_link);
								state_d = S_LIST;
							end else begin
								status_d = ST_LIST_EMPTY;
								state_d  = S_RESP;
							end
						end
						default: begin
						end
					endcase
				end
			end

			// Point the old tail forward at the new slot.
			S_APP_LINK: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = to_idx(p_q);
				mem_req.wr_mask = MASK_NEXT;
				mem_req.wr_data = '{value: '0, next: tail_q, prev: '0};
				state_d = S_RESP;
			end

			// Compare one entry per cycle and follow the forward link.
			S_WALK: begin
				if (rd_entry.value == req_q.value) begin
					status_d = ST_FOUND;
					if (req_q.func == FUNC_REMOVE) begin
						pool_cmd.drop = 1'b1;
						pool_cmd.slot = cur_q;
						p_d = rd_entry.prev;
						n_d = rd_entry.next;
						if (link_ok(rd_entry.prev)) begin
							mem_req.wr_en   = 1'b1;
							mem_req.wr_addr = to_idx(rd_entry.prev);
							mem_req.wr_mask = MASK_NEXT;
							mem_req.wr_data = '{value: '0, next: rd_entry.next, prev: '0};
						end else begin
							head_d = rd_entry.next;
						end
						if (!link_ok(rd_entry.next)) begin
							tail_d = rd_entry.prev;
						end
						state_d = S_UNLINK;
					end else begin
						state_d = S_RESP;
					end
				end else if (link_ok(rd_entry.next)) begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = to_idx(rd_entry.next);
					cur_d = to_idx(rd_entry.next);
				end else begin
					status_d = ST_NOT_FOUND;
					state_d  = S_RESP;
				end
			end

			// Point the successor back at the predecessor.
			S_UNLINK: begin
				if (link_ok(n_q)) begin
					mem_req.wr_en   = 1'b1;
					mem_req.wr_addr = to_idx(n_q);
					mem_req.wr_mask = MASK_PREV;
					mem_req.wr_data = '{value: '0, next: '0, prev: p_q};
				end
				state_d = S_RESP;
			end

			// One listed entry per free output slot.
			S_LIST: begin
				if (slot_free) begin
					rsp_load = 1'b1;
					rsp_d    = '{status: ST_LIST_ENTRY, item: rd_entry.value,
						last: !link_ok(list_link)};
					if (link_ok(list_link)) begin
						mem_req.rd_en   = 1'b1;
						mem_req.rd_addr = to_idx(list_link);
					end else begin
						state_d = S_IDLE;
					end
				end
			end

			// Single closing response word.
			S_RESP: begin
				if (slot_free) begin
					rsp_load = 1'b1;
					rsp_d    = '{status: status_q, item: req_q.value, last: 1'b1};
					state_d  = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= NULL_LINK;
			tail_q      <= NULL_LINK;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		req_q    <= req_d;
		cur_q    <= cur_d;
		p_q      <= p_d;
		n_q      <= n_d;
		status_q <= status_d;
		rsp_q    <= rsp_d;
	end

endmodule

`default_nettype wire

// ===== rtl/core/ordered_list_store_engine_unit.sv =====
// Top level: doubly linked list of signed words over a slot memory.
// Append: writes the new slot, then points the old tail at it when the list is not empty.
// Search: walks from the head comparing entries; a remove that matches adds an unlink step.
// Listing: one word per cycle while the response side is not stalled.
// One request at a time, paced by the single read port walking the links; stalls add cycles.
// Reset clears the pool flags, head, tail and control; the memory is not cleared.
`default_nettype none

module ordered_list_store_engine_unit
	import olse_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_stall,
	input  wire req_word_t req,
	output logic           rsp_valid,
	input  wire logic      rsp_stall,
	output rsp_word_t      rsp
);

	mem_req_t             mem_req;
	logic [ENTRY_W-1:0]   rd_bits;
	entry_t               rd_entry;
	pool_cmd_t            pool_cmd;
	pool_stat_t           pool_stat;

	assign rd_entry = entry_t'(rd_bits);

	// Sequencer.
	olse_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.mem_req   (mem_req),
		.rd_entry  (rd_entry),
		.pool_cmd  (pool_cmd),
		.pool_stat (pool_stat)
	);

	// Slot memory holding value and both links.
	olse_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk     (clk),
		.rd_en   (mem_req.rd_en),
		.rd_addr (mem_req.rd_addr),
		.rd_data (rd_bits),
		.wr_en   (mem_req.wr_en),
		.wr_addr (mem_req.wr_addr),
		.wr_mask (mem_req.wr_mask),
		.wr_data (mem_req.wr_data)
	);

	// Slot pool.
	olse_pool u_pool (
		.clk       (clk),
		.arst_n    (arst_n),
		.pool_cmd  (pool_cmd),
		.pool_stat (pool_stat)
	);

endmodule

`default_nettype wire

// ===== rtl/core/olse_checker.sv =====
// Port checker for the ordered list store engine and its bind.
`default_nettype none

module olse_checker
	import olse_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      req_valid,
	input wire logic      req_stall,
	input wire req_word_t req,
	input wire logic      rsp_valid,
	input wire logic      rsp_stall,
	input wire rsp_word_t rsp
);

	// A stalled response word stays put.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response word changed while stalled");

	// A valid request keeps the engine busy for at least the next cycle.
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && (req.func == FUNC_APPEND || req.func == FUNC_SEARCH
			|| req.func == FUNC_REMOVE || req.func == FUNC_LIST_FWD
			|| req.func == FUNC_LIST_BWD) |=> req_stall)
		else $error("request taken without the engine going busy");

	// Only listed entries may be non-final words.
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_LIST_ENTRY |-> rsp.last)
		else $error("single response word without last mark");

	// A new response word appears only while a request is in work.
	a_rsp_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("response word without a request in work");

endmodule

bind ordered_list_store_engine_unit olse_checker u_olse_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

`default_nettype wire

// ===== tb/sv/ordered_list_store_engine_unit_tb.sv =====
// Self-checking testbench of the ordered list store engine against a doubly linked list predictor.
module ordered_list_store_engine_unit_tb;
	import olse_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Request codes the block leaves unused; it must drop them without a response.
	localparam logic [2:0] FUNC_SPARE_5 = 3'd5;
	localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
	localparam logic [2:0] FUNC_SPARE_7 = 3'd7;

	localparam int RANDOM_WORDS = 420;
	localparam int DRAIN_CYCLES = 40;
	localparam int STUCK_LIMIT  = 2000;
	localparam int N_DIRECTED   = 25;

	typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIXED} mix_mode_e;

	// One directed request; a typed row carries its single expected status.
	typedef struct {
		logic [2:0]         func;
		logic signed [31:0] value;
		bit                 typed;
		logic [2:0]         status;
	} directed_row_t;

	logic      clk;
	logic      arst_n;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_word_t req = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_word_t rsp;

	// Shadow copy of the list held by the block.
	logic signed [31:0]  slot_val [CAPACITY];
	link_t               slot_next [CAPACITY];
	link_t               slot_prev [CAPACITY];
	logic [CAPACITY-1:0] used_slots = '0;
	link_t               list_head = NULL_LINK;
	link_t               list_tail = NULL_LINK;

	rsp_word_t step_rsp[$];
	rsp_word_t pending_rsp[$];
	int        mismatches = 0;
	int        send_idle_pct = 30;
	int        rsp_stall_pct = 60;
	int        stuck_cycles = 0;

	directed_row_t directed_rows [N_DIRECTED] = '{
		'{FUNC_LIST_FWD, 32'sh1234_5678, 1'b1, ST_LIST_EMPTY},
		'{FUNC_LIST_BWD, 32'shEDCB_A987, 1'b1, ST_LIST_EMPTY},
		'{FUNC_SEARCH,   32'sh0000_0000, 1'b1, ST_NOT_FOUND},
		'{FUNC_REMOVE,   32'sh0000_0005, 1'b1, ST_NOT_FOUND},
		'{FUNC_APPEND,   32'sh8000_0000, 1'b1, ST_APPENDED},
		'{FUNC_APPEND,   32'sh7FFF_FFFF, 1'b1, ST_APPENDED},
		'{FUNC_APPEND,   32'sh0000_0000, 1'b1, ST_APPENDED},
		'{FUNC_APPEND,   32'shFFFF_FFFF, 1'b1, ST_APPENDED},
		'{FUNC_LIST_FWD, 32'sh0000_0000, 1'b0, ST_LIST_ENTRY},
		'{FUNC_LIST_BWD, 32'sh0000_0000, 1'b0, ST_LIST_ENTRY},
		'{FUNC_SEARCH,   32'sh7FFF_FFFF, 1'b1, ST_FOUND},
		'{FUNC_SEARCH,   32'sh0000_0001, 1'b1, ST_NOT_FOUND},
		'{FUNC_SPARE_5,  32'sh0F0F_0F0F, 1'b0, ST_LIST_ENTRY},
		'{FUNC_REMOVE,   32'sh8000_0000, 1'b1, ST_FOUND},
		'{FUNC_REMOVE,   32'shFFFF_FFFF, 1'b1, ST_FOUND},
		'{FUNC_LIST_FWD, 32'sh0000_0000, 1'b0, ST_LIST_ENTRY},
		'{FUNC_APPEND,   32'sh0000_0000, 1'b1, ST_APPENDED},
		'{FUNC_REMOVE,   32'sh0000_0000, 1'b1, ST_FOUND},
		'{FUNC_LIST_BWD, 32'sh0000_0000, 1'b0, ST_LIST_ENTRY},
		'{FUNC_SPARE_6,  32'shF0F0_F0F0, 1'b0, ST_LIST_ENTRY},
		'{FUNC_SPARE_7,  32'sh5A5A_A5A5, 1'b0, ST_LIST_ENTRY},
		'{FUNC_REMOVE,   32'sh7FFF_FFFF, 1'b1, ST_FOUND},
		'{FUNC_REMOVE,   32'sh0000_0000, 1'b1, ST_FOUND},
		'{FUNC_LIST_FWD, 32'sh5555_5555, 1'b1, ST_LIST_EMPTY},
		'{FUNC_LIST_BWD, 32'shAAAA_AAAA, 1'b1, ST_LIST_EMPTY}
	};

	ordered_list_store_engine_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Walks from the head and returns the first slot holding the value, or the null link.
	function automatic link_t locate(input logic signed [31:0] v);
		link_t at;
		at = list_head;
		for (int steps = 0; steps < CAPACITY && at < NULL_LINK; steps++) begin
			if (slot_val[to_idx(at)] == v)
				return at;
			at = slot_next[to_idx(at)];
		end
		return NULL_LINK;
	endfunction

	// Applies one request to the shadow list and leaves its response words in step_rsp.
	task automatic list_apply(input req_word_t w);
		link_t at;
		link_t p;
		link_t n;
		int    free_idx;
		int    steps;
		bit    fwd;
		step_rsp.delete();
		case (w.func)
			FUNC_APPEND: begin
				free_idx = -1;
				for (int i = CAPACITY - 1; i >= 0; i--)
					if (!used_slots[i])
						free_idx = i;
				if (free_idx < 0) begin
					step_rsp.push_back('{status: ST_FULL, item: w.value, last: 1'b1});
				end else begin
					at = link_t'(free_idx);
					used_slots[to_idx(at)] = 1'b1;
					slot_val[to_idx(at)] = w.value;
					slot_next[to_idx(at)] = NULL_LINK;
					slot_prev[to_idx(at)] = list_tail;
					if (list_tail < NULL_LINK)
						slot_next[to_idx(list_tail)] = at;
					else
						list_head = at;
					list_tail = at;
					step_rsp.push_back('{status: ST_APPENDED, item: w.value, last: 1'b1});
				end
			end
			FUNC_SEARCH: begin
				at = locate(w.value);
				step_rsp.push_back('{status: (at < NULL_LINK) ? ST_FOUND : ST_NOT_FOUND,
					item: w.value, last: 1'b1});
			end
			FUNC_REMOVE: begin
				at = locate(w.value);
				if (at < NULL_LINK) begin
					p = slot_prev[to_idx(at)];
					n = slot_next[to_idx(at)];
					if (p < NULL_LINK)
						slot_next[to_idx(p)] = n;
					else
						list_head = n;
					if (n < NULL_LINK)
						slot_prev[to_idx(n)] = p;
					else
						list_tail = p;
					used_slots[to_idx(at)] = 1'b0;
					step_rsp.push_back('{status: ST_FOUND, item: w.value, last: 1'b1});
				end else begin
					step_rsp.push_back('{status: ST_NOT_FOUND, item: w.value, last: 1'b1});
				end
			end
			FUNC_LIST_FWD, FUNC_LIST_BWD: begin
				fwd = (w.func == FUNC_LIST_FWD);
				at = fwd ? list_head : list_tail;
				steps = 0;
				while (steps < CAPACITY && at < NULL_LINK) begin
					step_rsp.push_back('{status: ST_LIST_ENTRY, item: slot_val[to_idx(at)],
						last: 1'b0});
					at = fwd ? slot_next[to_idx(at)] : slot_prev[to_idx(at)];
					steps++;
				end
				if (steps == 0)
					step_rsp.push_back('{status: ST_LIST_EMPTY, item: w.value, last: 1'b1});
				else
					step_rsp[step_rsp.size() - 1].last = 1'b1;
			end
			default: begin
			end
		endcase
	endtask

	// Offers one request word after a random gap and records what it should cause.
	task automatic send_word(input req_word_t w, input bit typed, input logic [2:0] typed_status);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req <= w;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (req_stall);
		list_apply(w);
		if (typed)
			pending_rsp.push_back('{status: typed_status, item: w.value, last: 1'b1});
		else
			foreach (step_rsp[i])
				pending_rsp.push_back(step_rsp[i]);
	endtask

	// Picks a value: often one already stored, else small, extreme or fully random.
	function automatic logic signed [31:0] pick_value(input int present_pct);
		link_t at;
		int    hops;
		if ($urandom_range(99) < present_pct && used_slots != '0) begin
			hops = $urandom_range($countones(used_slots) - 1);
			at = list_head;
			repeat (hops)
				at = slot_next[to_idx(at)];
			return slot_val[to_idx(at)];
		end
		case ($urandom_range(9))
			0, 1, 2, 3: return 32'($urandom_range(8)) - 32'd4;
			4: return 32'sh8000_0000;
			5: return 32'sh7FFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic req_word_t random_word(input mix_mode_e mode);
		int unsigned r;
		int          app;
		int          srch;
		int          rem;
		case (mode)
			MODE_GROW:   begin app = 75; srch = 8;  rem = 7;  end
			MODE_SHRINK: begin app = 15; srch = 15; rem = 60; end
			default:     begin app = 35; srch = 25; rem = 30; end
		endcase
		r = $urandom_range(99);
		if (r < app)
			return '{func: FUNC_APPEND, value: pick_value(20)};
		if (r < app + srch)
			return '{func: FUNC_SEARCH, value: pick_value(50)};
		if (r < app + srch + rem)
			return '{func: FUNC_REMOVE, value: pick_value(70)};
		return '{func: $urandom_range(1) ? FUNC_LIST_FWD : FUNC_LIST_BWD, value: $urandom};
	endfunction

	task automatic flag_mismatch(input string what, input rsp_word_t want, input rsp_word_t got);
		if (mismatches < 10)
			$display("%0t %s: expected status %0d item %0d last %0d, got status %0d item %0d last %0d",
				$realtime, what, want.status, want.item, want.last, got.status, got.item, got.last);
		mismatches++;
	endtask

	// Response side: check each accepted word, then choose the next stall.
	always @(posedge clk) begin
		rsp_word_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				flag_mismatch("unexpected word", '0, rsp);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.status !== want.status || rsp.item !== want.item
						|| rsp.last !== want.last)
					flag_mismatch("wrong word", want, rsp);
			end
		end
		rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
	end

	// Watchdog: too long without any word moving on either side ends the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				stuck_cycles <= 0;
			else
				stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// Stimulus: reset, directed table, then random traffic in three idling phases.
	initial begin
		mix_mode_e mode;
		logic [2:0] spare;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_word('{func: directed_rows[i].func, value: directed_rows[i].value},
				directed_rows[i].typed, directed_rows[i].status);

		// Start by growing so the list fills up and overflows early.
		mode = MODE_GROW;
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i == 140) begin
				send_idle_pct = 60;
				rsp_stall_pct = 30;
			end else if (i == 280) begin
				send_idle_pct = 0;
				rsp_stall_pct = 0;
			end
			if (i >= 60 && i % 30 == 0)
				mode = mix_mode_e'($urandom_range(2));
			if ($urandom_range(99) < 4) begin
				case ($urandom_range(2))
					0: spare = FUNC_SPARE_5;
					1: spare = FUNC_SPARE_6;
					default: spare = FUNC_SPARE_7;
				endcase
				send_word('{func: spare, value: $urandom}, 1'b0, ST_LIST_ENTRY);
			end
			send_word(random_word(mode), 1'b0, ST_LIST_ENTRY);
		end
		req_valid <= 1'b0;

		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== ordered_list_store_engine_unit.f =====
rtl/core/olse_pkg.sv
rtl/core/olse_ram.sv
rtl/core/olse_pool.sv
rtl/core/olse_seq.sv
rtl/core/ordered_list_store_engine_unit.sv
rtl/core/olse_checker.sv
tb/sv/ordered_list_store_engine_unit_tb.sv
